[hdl/spq_pkg.sv]
// shared types, codes and defaults of the sorted priority queue
`default_nettype none
package spq_pkg;

	// default queue depth
	localparam int SPQ_DEPTH = 16;

	// request kinds
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// request item
	typedef struct packed {
		logic               req_type;
		logic signed [31:0] new_value;
		logic        [7:0]  new_priority;
	} spq_req_t;

	// result item
	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] head_value;
		logic        [7:0]  head_priority;
		logic        [4:0]  occupancy;
	} spq_rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
	} spq_cmd_t;

endpackage
`default_nettype wire

[hdl/sorted_priority_queue_unit.sv]
// top level of the sorted priority queue
//
//  channel | direction | payload    | handshake
//  req     | in        | spq_req_t  | req_valid / req_stall
//  rsp     | out       | spq_rsp_t  | rsp_valid / rsp_stall
//
// one item per cycle unless a stalled result holds it; its result shows in the cycle after acceptance
// all cells compare with the new priority and shift in the same cycle
// a new item is taken while a result waits, unless rsp_stall holds it
// reset clears the occupancy and the result valid; entries and result data are not cleared
`default_nettype none
module sorted_priority_queue_unit #(
	parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_stall,
	input  wire spq_pkg::spq_req_t req,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output spq_pkg::spq_rsp_t      rsp
);
	import spq_pkg::*;

	spq_cmd_t cmd;

	// handshake control
	spq_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// entry cells and result
	spq_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

[hdl/spq_datapath.sv]
// entry cells, occupancy count and result register of the priority queue
`default_nettype none
module spq_datapath #(
	parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire spq_pkg::spq_cmd_t cmd,
	input  wire spq_pkg::spq_req_t req,
	output spq_pkg::spq_rsp_t      rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] val_q [DEPTH];
	logic        [7:0]  pri_q [DEPTH];
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_d;
	logic [DEPTH-1:0]   ge;
	logic               full;
	logic               empty;
	logic               do_enq;
	logic               do_deq;
	logic [CW+4:0]      occ_wide;
	spq_rsp_t           res_d;
	spq_rsp_t           res_q;

	// each cell flags whether it lies at or past the insertion point
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CW'(i) >= cnt_q) || (pri_q[i] < req.new_priority);
		end
	end

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_enq = cmd.load && (req.req_type == REQ_ENQ) && !full;
	assign do_deq = cmd.load && (req.req_type == REQ_DEQ) && !empty;

	// compare-and-shift cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_enq && ge[g]) begin
				if (g == 0) begin
					val_q[g] <= req.new_value;
					pri_q[g] <= req.new_priority;
				end else if (!ge[(g == 0) ? 0 : g - 1]) begin
					val_q[g] <= req.new_value;
					pri_q[g] <= req.new_priority;
				end else begin
					val_q[g] <= val_q[(g == 0) ? 0 : g - 1];
					pri_q[g] <= pri_q[(g == 0) ? 0 : g - 1];
				end
			end else if (do_deq && (g < DEPTH - 1)) begin
				val_q[g] <= val_q[(g < DEPTH - 1) ? g + 1 : g];
				pri_q[g] <= pri_q[(g < DEPTH - 1) ? g + 1 : g];
			end
		end
	end

	// occupancy after the item
	always_comb begin
		cnt_d = cnt_q;
		if (do_enq) begin
			cnt_d = cnt_q + CW'(1);
		end else if (do_deq) begin
			cnt_d = cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// result of the item
	assign occ_wide = {5'd0, cnt_d};

	always_comb begin
		res_d.status        = ST_DONE;
		res_d.head_value    = '0;
		res_d.head_priority = '0;
		res_d.occupancy     = occ_wide[4:0];
		if (req.req_type == REQ_ENQ) begin
			if (full) begin
				res_d.status = ST_FULL;
			end
		end else begin
			if (empty) begin
				res_d.status = ST_EMPTY;
			end else begin
				res_d.head_value    = val_q[0];
				res_d.head_priority = pri_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q <= res_d;
		end
	end

	assign rsp = res_q;

endmodule
`default_nettype wire

[hdl/spq_controller.sv]
// handshake controller of the priority queue
`default_nettype none
module spq_controller (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output spq_pkg::spq_cmd_t cmd
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	// take an item unless a held result is stalled
	assign req_stall = (state_q == S_HOLD) && rsp_stall;
	assign rsp_valid = (state_q == S_HOLD);
	assign cmd.load  = req_valid && !req_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (!rsp_stall && !cmd.load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hdl/spq_checker.sv]
// port checker of the sorted priority queue and its bind
`default_nettype none
module spq_checker #(
	parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    req_valid,
	input wire                    req_stall,
	input wire                    rsp_valid,
	input wire                    rsp_stall,
	input wire spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	localparam logic [4:0] DEPTH_OCC = 5'(DEPTH);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// a result appears only after an accepted item
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall))
		else $error("result without item");

	// refused dequeue reports an empty queue and no head
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |->
			(rsp.occupancy == 5'd0) && (rsp.head_value == '0) && (rsp.head_priority == '0))
		else $error("bad empty result");

	// refused enqueue reports a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> (rsp.occupancy == DEPTH_OCC))
		else $error("bad full result");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
